/* rtl/assert_macros.svh */
// Assertion helpers, included by interval_first_fit_partition.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/iffp_pkg.sv */
package iffp_pkg;

    localparam int TIME_W  = 16;
    localparam int LABEL_W = 5;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Finished result word handed from the scanner to the output stage.
    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] label;
    } t_result;

endpackage

/* rtl/interval_first_fit_partition.sv */
// Interval partitioning, first fit.
// Input channel: i_valid / o_stall carry one request word (start time, finish
// time, first-of-batch flag); a word is taken at an edge with i_valid high
// and o_stall low. Output channel: o_valid / i_stall carry one label word per
// request; 0 means no searched resource fits.
// i_cfg_we / i_cfg_data write the number of resources searched (clamped to
// 1..RESOURCES); write it only while no request is in flight.
// The scan reads one stored end time per cycle from the end-time memory and
// stops at the first fit; a new request is taken only while the scanner is
// idle, so one request is scanned at a time.
// A new request is accepted while the previous label still waits in the
// output register; if the receiver stalls, a finished scan holds its label
// and o_stall stays high until the output register frees up.
// Reset (i_rst_n low, synchronous) marks every resource free, sets the search
// depth to 16 and empties the output register. End times are not cleared;
// an entry's stored end time is used only after it has been written.
`include "assert_macros.svh"

module interval_first_fit_partition #(
    parameter int RESOURCES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [iffp_pkg::TIME_W-1:0]   i_start_time,
    input  logic [iffp_pkg::TIME_W-1:0]   i_finish_time,
    input  logic                          i_first_of_batch,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [iffp_pkg::LABEL_W-1:0]  o_label,
    input  logic                          i_cfg_we,
    input  logic [iffp_pkg::CFG_W-1:0]    i_cfg_data
);

    import iffp_pkg::*;

    localparam int IDX_W = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int CNT_W = $clog2(RESOURCES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    // labels wrap in the 5-bit field once the table has 32 entries or more
    localparam int MAX_LABEL = (RESOURCES < 32) ? RESOURCES : 31;

    logic [CFG_W-1:0]   r_cfg;
    logic               r_ovalid;
    logic [LABEL_W-1:0] r_olabel;

    logic [CMP_W-1:0]   w_cfg_ext;
    logic [CNT_W-1:0]   w_n;
    logic               w_in_acc;
    logic               w_take;
    logic               w_busy;
    t_result            w_res;

    assign w_cfg_ext = CMP_W'(r_cfg);

    always_comb begin
        priority if (w_cfg_ext == '0) begin
            w_n = CNT_W'(1);
        end else if (w_cfg_ext > CMP_W'(RESOURCES)) begin
            w_n = CNT_W'(RESOURCES);
        end else begin
            w_n = CNT_W'(w_cfg_ext);
        end
    end

    assign w_in_acc = i_valid && !o_stall;
    assign w_take   = w_res.valid && (!r_ovalid || !i_stall);

    iffp_scan #(
        .RESOURCES (RESOURCES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (w_in_acc),
        .i_start  (i_start_time),
        .i_finish (i_finish_time),
        .i_first  (i_first_of_batch),
        .i_n      (w_n),
        .i_take   (w_take),
        .o_busy   (w_busy),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (w_take) begin
                r_ovalid <= 1'b1;
                r_olabel <= w_res.label;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stall = w_busy;
    assign o_valid = r_ovalid;
    assign o_label = r_olabel;

    `ASSERT_CLK_ALL(a_reset_empty, !i_rst_n |=> !o_valid, "output valid right after reset")
    `ASSERT_CLK(a_accept_busy, (i_valid && !o_stall) |=> o_stall, "scan not started on accept")
    `ASSERT_CLK(a_idle_after_take, $fell(o_stall) |-> $past(w_take), "scan left without a result")
    `ASSERT_CLK(a_label_range, o_valid |-> (o_label <= LABEL_W'(MAX_LABEL)), "label too large")

endmodule

/* rtl/iffp_mem.sv */
module iffp_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/iffp_scan.sv */
module iffp_scan #(
    parameter int RESOURCES = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_acc,
    input  logic [iffp_pkg::TIME_W-1:0] i_start,
    input  logic [iffp_pkg::TIME_W-1:0] i_finish,
    input  logic                     i_first,
    input  logic [CNT_W-1:0]         i_n,
    input  logic                     i_take,
    output logic                     o_busy,
    output iffp_pkg::t_result        o_res
);

    import iffp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [RESOURCES-1:0] r_busy;
    logic [TIME_W-1:0]    r_start;
    logic [TIME_W-1:0]    r_finish;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_ridx;
    logic [CNT_W-1:0]     r_cidx;
    logic                 r_cvalid;
    logic [LABEL_W-1:0]   r_label;

    logic                 w_issue;
    logic                 w_fit;
    logic                 w_last;
    logic [TIME_W-1:0]    w_rdata;
    logic [IDX_W-1:0]     w_cix;
    logic [IDX_W:0]       w_lab;

    assign w_issue = (r_state == S_SCAN) && (r_ridx < r_n);
    assign w_cix   = r_cidx[IDX_W-1:0];
    // free entries fit without looking at the stored end time
    assign w_fit   = (r_state == S_SCAN) && r_cvalid
                     && (!r_busy[w_cix] || (w_rdata < r_start));
    assign w_last  = (r_cidx + {{(CNT_W-1){1'b0}}, 1'b1}) == r_n;
    assign w_lab   = {1'b0, w_cix} + {{IDX_W{1'b0}}, 1'b1};

    iffp_mem #(
        .DEPTH (RESOURCES),
        .AW    (IDX_W),
        .DW    (TIME_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (w_issue),
        .i_raddr (r_ridx[IDX_W-1:0]),
        .o_rdata (w_rdata),
        .i_we    (w_fit),
        .i_waddr (w_cix),
        .i_wdata (r_finish)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= '0;
            r_cvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cvalid <= 1'b0;
                    if (i_acc) begin
                        r_start  <= i_start;
                        r_finish <= i_finish;
                        r_n      <= i_n;
                        r_ridx   <= '0;
                        if (i_first) begin
                            r_busy <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one read issued per cycle, compared in the following cycle
                    r_cvalid <= w_issue;
                    r_cidx   <= r_ridx;
                    if (w_issue) begin
                        r_ridx <= r_ridx + {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                    if (w_fit) begin
                        r_busy[w_cix] <= 1'b1;
                        r_label       <= LABEL_W'(w_lab);
                        r_state       <= S_DONE;
                    end else if (r_cvalid && w_last) begin
                        r_label <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_cvalid <= 1'b0;
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.label = r_label;

endmodule
